// ----- design/ldf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_pkg
// Shared types and constants of the lidar sample deframer.
// ----------------------------------------------------------------------------
package ldf_pkg;

  localparam int WINDOW_BYTES    = 15;
  localparam int PKT_BYTES       = 5;
  localparam int DEGREES_PER_BIN = 1;

  localparam int FILL_W = 4;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_BYTES - 1);
  localparam logic [FILL_W-1:0] FILL_AFTER_PKT = FILL_W'(WINDOW_BYTES - PKT_BYTES);

  // angles in Q6 degrees
  localparam int ANGLE_W = 15;
  localparam int MATH_W  = 17;
  localparam int Q6_SHIFT = 6;
  localparam logic [MATH_W-1:0] FULL_TURN_Q6 = MATH_W'(23040);
  localparam logic [MATH_W-1:0] MIRROR_Q6    = MATH_W'(28800);
  localparam logic [MATH_W-1:0] WRAP_Q6      = MATH_W'(28800 + 23040);

  // bin = degrees / DEGREES_PER_BIN by reciprocal, exact for degrees < 360
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] BIN_RECIP =
    RECIP_W'((2**RECIP_SHIFT + DEGREES_PER_BIN - 1) / DEGREES_PER_BIN);
  localparam int BIN_W = 9;
  localparam int DEG_W = ANGLE_W - Q6_SHIFT;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CLIP_EN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIP_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_INF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST    = 3'd4;

  localparam logic [15:0] MIN_DIST_RESET = 16'd400;
  localparam logic [15:0] MAX_DIST_RESET = 16'd10000;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT1,
    CELL_SHIFT5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  typedef struct packed {
    logic        min_clip_enable;
    logic        max_clip_enable;
    logic        keep_infinite;
    logic [15:0] min_distance_qmm;
    logic [15:0] max_distance_qmm;
  } cfg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [15:0]      distance_qmm;
    logic             is_infinite;
    logic [5:0]       quality;
    logic             scan_start;
  } sample_t;

endpackage
`default_nettype wire

// ----- design/ldf_byte_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_byte_if
// Serial byte channel, one byte per item.
// ----------------------------------------------------------------------------
interface ldf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] serial_byte;

  modport source (output valid, output serial_byte, input ready);
  modport sink   (input valid, input serial_byte, output ready);
endinterface
`default_nettype wire

// ----- design/ldf_sample_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_sample_if
// Decoded sample channel, one bin and distance per item.
// ----------------------------------------------------------------------------
interface ldf_sample_if;
  logic        valid;
  logic        ready;
  logic [8:0]  bin_index;
  logic [15:0] distance_qmm;
  logic        is_infinite;
  logic [5:0]  quality;
  logic        scan_start;

  modport source (output valid, output bin_index, output distance_qmm,
                  output is_infinite, output quality, output scan_start, input ready);
  modport sink   (input valid, input bin_index, input distance_qmm,
                  input is_infinite, input quality, input scan_start, output ready);
endinterface
`default_nettype wire

// ----- design/ldf_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_cell
// One byte of the window: holds, loads a new byte or takes a neighbour's.
// ----------------------------------------------------------------------------
module ldf_cell
  import ldf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire logic [7:0] load_byte,
  input  wire logic [7:0] near_byte,
  input  wire logic [7:0] far_byte,
  output logic [7:0]     value
);

  logic [7:0] value_next;

  always_comb begin
    case (ctl.op)
      CELL_LOAD:   value_next = load_byte;
      CELL_SHIFT1: value_next = near_byte;
      CELL_SHIFT5: value_next = far_byte;
      default:     value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/ldf_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_decode
// Decodes one packet: mirrored angle bin, distance clipping, flags.
// ----------------------------------------------------------------------------
module ldf_decode
  import ldf_pkg::*;
(
  input  wire logic [7:0] b0,
  input  wire logic [7:0] b1,
  input  wire logic [7:0] b2,
  input  wire logic [7:0] b3,
  input  wire logic [7:0] b4,
  input  wire cfg_t       cfg,
  output sample_t         sample
);

  logic [ANGLE_W-1:0]         angle;
  logic [MATH_W-1:0]          diff;
  logic [MATH_W-1:0]          wrapped;
  logic [DEG_W-1:0]           deg;
  logic [DEG_W+RECIP_W-1:0]   prod;
  logic [15:0]                raw_dist;
  logic [15:0]                clipped;
  logic                       inf;
  logic                       inf_out;

  always_comb begin
    angle = {b2, b1[7:1]};
    if (MATH_W'(angle) <= MIRROR_Q6) begin
      diff = MIRROR_Q6 - MATH_W'(angle);
    end else begin
      diff = WRAP_Q6 - MATH_W'(angle);
    end
    wrapped = (diff >= FULL_TURN_Q6) ? diff - FULL_TURN_Q6 : diff;
    deg     = wrapped[ANGLE_W-1:Q6_SHIFT];
    prod    = (DEG_W+RECIP_W)'(deg) * (DEG_W+RECIP_W)'(BIN_RECIP);

    raw_dist = {b4, b3};
    inf      = (b0[7:2] == 6'd0);
    clipped  = raw_dist;
    inf_out  = inf;
    if (cfg.min_clip_enable && !inf && raw_dist < cfg.min_distance_qmm) begin
      clipped = cfg.max_distance_qmm;
    end
    if (cfg.max_clip_enable && !cfg.keep_infinite &&
        (inf || clipped > cfg.max_distance_qmm)) begin
      clipped = cfg.max_distance_qmm;
      inf_out = 1'b0;
    end
    if (inf_out) begin
      clipped = '0;
    end

    sample.bin_index    = prod[RECIP_SHIFT +: BIN_W];
    sample.distance_qmm = clipped;
    sample.is_infinite  = inf_out;
    sample.quality      = b0[7:2];
    sample.scan_start   = b0[0];
  end

endmodule
`default_nettype wire

// ----- design/ldf_out_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ldf_out_queue
// Two-entry output queue between the decoder and the sample channel.
// ----------------------------------------------------------------------------
module ldf_out_queue
  import ldf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire sample_t   push_data,
  output logic           full,
  ldf_sample_if.source   samples
);

  sample_t    slot0;
  sample_t    slot1;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;
  logic [1:0] wr_pos;

  assign pop  = samples.valid && samples.ready;
  assign full = (count == 2'd2);
  assign wr_pos = count - {1'b0, pop};
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= slot1;
    end
    if (push && wr_pos == 2'd0) begin
      slot0 <= push_data;
    end
    if (push && wr_pos == 2'd1) begin
      slot1 <= push_data;
    end
  end

  assign samples.valid        = (count != 2'd0);
  assign samples.bin_index    = slot0.bin_index;
  assign samples.distance_qmm = slot0.distance_qmm;
  assign samples.is_infinite  = slot0.is_infinite;
  assign samples.quality      = slot0.quality;
  assign samples.scan_start   = slot0.scan_start;

endmodule
`default_nettype wire

// ----- design/lidar_sample_deframer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_sample_deframer
// Serial byte window and packet sync, decoding bin and clipped distance.
// A result is registered in the output queue, valid in the cycle after the byte that completes it.
// Throughput: one byte per cycle while the output queue is not full, set by the byte window cells.
// Ready drops only while two results wait in the output queue.
// Reset (sync, active high) empties the window and queue, restores registers.
// ----------------------------------------------------------------------------
module lidar_sample_deframer
  import ldf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  ldf_byte_if.sink                   byte_ch,
  ldf_sample_if.source               sample_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // the last window byte is always the incoming one, so one cell fewer is held
  cfg_t              cfg;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [7:0]        cells [WINDOW_BYTES - 1];
  logic [7:0]        taps  [WINDOW_BYTES + PKT_BYTES - 1];
  cell_ctl_t         ctl   [WINDOW_BYTES - 1];
  logic              accept;
  logic              last_byte;
  logic              sync_ok;
  logic              q_full;
  sample_t           decoded;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_clip_enable  <= 1'b0;
      cfg.max_clip_enable  <= 1'b0;
      cfg.keep_infinite    <= 1'b0;
      cfg.min_distance_qmm <= MIN_DIST_RESET;
      cfg.max_distance_qmm <= MAX_DIST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_CLIP_EN: cfg.min_clip_enable  <= cfg_data[0];
        REG_MAX_CLIP_EN: cfg.max_clip_enable  <= cfg_data[0];
        REG_KEEP_INF:    cfg.keep_infinite    <= cfg_data[0];
        REG_MIN_DIST:    cfg.min_distance_qmm <= cfg_data;
        REG_MAX_DIST:    cfg.max_distance_qmm <= cfg_data;
        default: ;
      endcase
    end
  end

  assign byte_ch.ready = !q_full;
  assign accept    = byte_ch.valid && byte_ch.ready;
  assign last_byte = (fill == FILL_LAST);

  // window as seen with the incoming byte appended; zeros past the end
  always_comb begin
    for (int i = 0; i < WINDOW_BYTES + PKT_BYTES - 1; i++) begin
      if (i < WINDOW_BYTES - 1) begin
        taps[i] = cells[i];
      end else if (i == WINDOW_BYTES - 1) begin
        taps[i] = byte_ch.serial_byte;
      end else begin
        taps[i] = '0;
      end
    end
  end

  always_comb begin
    sync_ok = !(taps[0][0] && taps[PKT_BYTES][0]);
    for (int p = 0; p < WINDOW_BYTES; p += PKT_BYTES) begin
      if ((taps[p][0] == taps[p][1]) || !taps[p+1][0]) begin
        sync_ok = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
      if (!accept) begin
        ctl[i].op = CELL_HOLD;
      end else if (!last_byte) begin
        ctl[i].op = (fill == FILL_W'(i)) ? CELL_LOAD : CELL_HOLD;
      end else begin
        ctl[i].op = sync_ok ? CELL_SHIFT5 : CELL_SHIFT1;
      end
    end
  end

  always_comb begin
    fill_next = fill;
    if (accept) begin
      if (!last_byte) begin
        fill_next = fill + 1'b1;
      end else if (sync_ok) begin
        fill_next = FILL_AFTER_PKT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  for (genvar g = 0; g < WINDOW_BYTES - 1; g++) begin : g_cell
    ldf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[g]),
      .load_byte (byte_ch.serial_byte),
      .near_byte (taps[g+1]),
      .far_byte  (taps[g+PKT_BYTES]),
      .value     (cells[g])
    );
  end

  ldf_decode u_decode (
    .b0     (taps[0]),
    .b1     (taps[1]),
    .b2     (taps[2]),
    .b3     (taps[3]),
    .b4     (taps[4]),
    .cfg    (cfg),
    .sample (decoded)
  );

  ldf_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && last_byte && sync_ok),
    .push_data (decoded),
    .full      (q_full),
    .samples   (sample_ch)
  );

endmodule
`default_nettype wire
